// ===== sv/grid_astar_path_finder_defines.svh =====
// Assertion macros shared by the path finder RTL.
`ifndef GRID_ASTAR_PATH_FINDER_DEFINES_SVH
`define GRID_ASTAR_PATH_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
`define GAPF_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GAPF_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GAPF_CHECK(lbl, prop, msg)
`define GAPF_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/gapf_pkg.sv =====
// Types, codes and constants of the grid path finder.
package gapf_pkg;

	localparam int GRID_W_DEF     = 128;
	localparam int GRID_H_DEF     = 128;
	localparam int OPEN_DEPTH_DEF = 4096;

	localparam int COORD_W = 8;
	localparam int COST_W  = 17;
	localparam int F_W     = 18;
	localparam int SEQ_W   = 18;

	localparam logic [7:0] MAP_W_RESET = 8'd100;
	localparam logic [7:0] MAP_H_RESET = 8'd100;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_FOUND    = 3'd1,
		ST_NO_PATH  = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_TILE   = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		S_CLR_TILE,
		S_IDLE,
		S_CLR_NODE,
		S_SEED,
		S_POP,
		S_POP_WAIT,
		S_NB,
		S_NB_CHK,
		S_TB_RD,
		S_TB_STEP,
		S_RD_PATH,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_UP_RD,
		H_UP_CMP,
		H_POP_LD,
		H_DN_RD,
		H_DN_CMP
	} heap_state_t;

	typedef struct packed {
		logic [F_W-1:0]     f;
		logic [SEQ_W-1:0]   seq;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COST_W-1:0]  g;
	} open_entry_t;

	typedef struct packed {
		logic              seen;
		logic [COST_W-1:0] cost;
		dir_t              dir;
	} node_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} heap_req_t;

	typedef struct packed {
		logic busy;
		logic empty;
		logic full;
	} heap_stat_t;

	typedef struct packed {
		logic                 tile_we;
		logic                 closed_we;
		logic                 node_we;
		logic                 path_we;
		logic                 tile_d;
		logic                 closed_d;
		node_t                node_d;
		logic [2*COORD_W-1:0] path_d;
	} store_wr_t;

	function automatic logic goes_before(open_entry_t a, open_entry_t b);
		return (a.f < b.f) || ((a.f == b.f) && (a.seq < b.seq));
	endfunction

endpackage

// ===== sv/gapf_cell_store.sv =====
// Per-cell storage: obstacle bits, closed marks, node records and path cells.
module gapf_cell_store #(
	parameter int CELLS = gapf_pkg::GRID_W_DEF * gapf_pkg::GRID_H_DEF
) (
	input  logic                                clk,
	input  logic [$clog2(CELLS)-1:0]            wr_addr,
	input  gapf_pkg::store_wr_t                 wr,
	input  logic [$clog2(CELLS)-1:0]            rd_addr,
	output logic                                tile_q,
	output logic                                closed_q,
	output gapf_pkg::node_t                     node_q,
	output logic [2*gapf_pkg::COORD_W-1:0]      path_q
);

	logic                             tile_mem   [CELLS];
	logic                             closed_mem [CELLS];
	gapf_pkg::node_t                  node_mem   [CELLS];
	logic [2*gapf_pkg::COORD_W-1:0]   path_mem   [CELLS];

	always_ff @(posedge clk) begin
		if (wr.tile_we) begin
			tile_mem[wr_addr] <= wr.tile_d;
		end
		if (wr.closed_we) begin
			closed_mem[wr_addr] <= wr.closed_d;
		end
		if (wr.node_we) begin
			node_mem[wr_addr] <= wr.node_d;
		end
		if (wr.path_we) begin
			path_mem[wr_addr] <= wr.path_d;
		end
	end

	always_ff @(posedge clk) begin
		tile_q   <= tile_mem[rd_addr];
		closed_q <= closed_mem[rd_addr];
		node_q   <= node_mem[rd_addr];
		path_q   <= path_mem[rd_addr];
	end

endmodule

// ===== sv/gapf_open_heap.sv =====
// Open list: binary min-heap in one memory with a sift-up/sift-down sequencer.
module gapf_open_heap #(
	parameter int OPEN_DEPTH = gapf_pkg::OPEN_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gapf_pkg::heap_req_t    req,
	input  gapf_pkg::open_entry_t  push_entry,
	output gapf_pkg::heap_stat_t   stat,
	output gapf_pkg::open_entry_t  top
);

	localparam int HAW   = $clog2(OPEN_DEPTH);
	localparam int CNT_W = $clog2(OPEN_DEPTH + 1);
	localparam int IDX_W = CNT_W + 1;

	gapf_pkg::open_entry_t heap_mem [OPEN_DEPTH];

	gapf_pkg::heap_state_t state_q, nxt_state;
	logic [CNT_W-1:0]          cnt_q, nxt_cnt;
	logic [gapf_pkg::SEQ_W-1:0] seq_q, nxt_seq;
	logic [IDX_W-1:0]          hole_q, nxt_hole;
	gapf_pkg::open_entry_t     ent_q, nxt_ent;
	gapf_pkg::open_entry_t     top_q, nxt_top;
	gapf_pkg::open_entry_t     rd_a_q, rd_b_q;
	gapf_pkg::open_entry_t     wdata, best;

	logic [HAW-1:0]   raddr_a, raddr_b, waddr;
	logic             we;
	logic [IDX_W-1:0] lidx, ridx, pidx;
	logic             pick_l, pick_r;

	assign lidx = (hole_q << 1) + IDX_W'(1);
	assign ridx = lidx + IDX_W'(1);
	assign pidx = (hole_q - IDX_W'(1)) >> 1;

	always_comb begin
		nxt_state = state_q;
		nxt_cnt   = cnt_q;
		nxt_seq   = seq_q;
		nxt_hole  = hole_q;
		nxt_ent   = ent_q;
		nxt_top   = top_q;
		raddr_a   = pidx[HAW-1:0];
		raddr_b   = lidx[HAW-1:0];
		we        = 1'b0;
		waddr     = hole_q[HAW-1:0];
		wdata     = ent_q;
		pick_l    = gapf_pkg::goes_before(rd_a_q, ent_q);
		best      = pick_l ? rd_a_q : ent_q;
		pick_r    = (ridx < IDX_W'(cnt_q)) && gapf_pkg::goes_before(rd_b_q, best);
		case (state_q)
			gapf_pkg::H_IDLE: begin
				if (req.clear) begin
					nxt_cnt = '0;
					nxt_seq = '0;
				end else if (req.push) begin
					nxt_ent     = push_entry;
					nxt_ent.seq = seq_q;
					nxt_seq     = seq_q + gapf_pkg::SEQ_W'(1);
					nxt_hole    = IDX_W'(cnt_q);
					nxt_cnt     = cnt_q + CNT_W'(1);
					nxt_state   = gapf_pkg::H_UP_RD;
				end else if (req.pop) begin
					raddr_a   = '0;
					raddr_b   = HAW'(cnt_q - CNT_W'(1));
					nxt_cnt   = cnt_q - CNT_W'(1);
					nxt_state = gapf_pkg::H_POP_LD;
				end
			end
			gapf_pkg::H_UP_RD: begin
				if (hole_q == '0) begin
					we        = 1'b1;
					nxt_state = gapf_pkg::H_IDLE;
				end else begin
					nxt_state = gapf_pkg::H_UP_CMP;
				end
			end
			gapf_pkg::H_UP_CMP: begin
				we = 1'b1;
				if (gapf_pkg::goes_before(ent_q, rd_a_q)) begin
					wdata     = rd_a_q;
					nxt_hole  = pidx;
					nxt_state = gapf_pkg::H_UP_RD;
				end else begin
					nxt_state = gapf_pkg::H_IDLE;
				end
			end
			gapf_pkg::H_POP_LD: begin
				nxt_top   = rd_a_q;
				nxt_ent   = rd_b_q;
				nxt_hole  = '0;
				nxt_state = (cnt_q == '0) ? gapf_pkg::H_IDLE : gapf_pkg::H_DN_RD;
			end
			gapf_pkg::H_DN_RD: begin
				raddr_a = lidx[HAW-1:0];
				raddr_b = (ridx < IDX_W'(cnt_q)) ? ridx[HAW-1:0] : lidx[HAW-1:0];
				if (lidx >= IDX_W'(cnt_q)) begin
					we        = 1'b1;
					nxt_state = gapf_pkg::H_IDLE;
				end else begin
					nxt_state = gapf_pkg::H_DN_CMP;
				end
			end
			gapf_pkg::H_DN_CMP: begin
				we = 1'b1;
				if (pick_r) begin
					wdata     = rd_b_q;
					nxt_hole  = ridx;
					nxt_state = gapf_pkg::H_DN_RD;
				end else if (pick_l) begin
					wdata     = rd_a_q;
					nxt_hole  = lidx;
					nxt_state = gapf_pkg::H_DN_RD;
				end else begin
					nxt_state = gapf_pkg::H_IDLE;
				end
			end
			default: begin
				nxt_state = gapf_pkg::H_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gapf_pkg::H_IDLE;
			cnt_q   <= '0;
			seq_q   <= '0;
		end else begin
			state_q <= nxt_state;
			cnt_q   <= nxt_cnt;
			seq_q   <= nxt_seq;
		end
	end

	always_ff @(posedge clk) begin
		hole_q <= nxt_hole;
		ent_q  <= nxt_ent;
		top_q  <= nxt_top;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[waddr] <= wdata;
		end
		rd_a_q <= heap_mem[raddr_a];
		rd_b_q <= heap_mem[raddr_b];
	end

	assign stat.busy  = (state_q != gapf_pkg::H_IDLE);
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q >= CNT_W'(OPEN_DEPTH));
	assign top        = top_q;

endmodule

// ===== sv/grid_astar_path_finder.sv =====
// Top level of the grid A* path finder: command sequencer, config and result register.
// After reset the block clears the obstacle map cell by cell and accepts no word
// until then; configuration writes are taken at any time. A tile write, an off-map
// search, an out-of-range read and an unused mode go straight to the result
// register, while a path cell read first reads the path store. A search first clears
// the per-cell marks, then for each expanded cell does one heap pop (a sift-down over
// the heap levels), checks each neighbor in turn and hands an accepted neighbor to
// a heap push in the background (a sift-up), and finally traces the path back one
// cell at a time. The single read port of the cell store and the heap sequencer set
// the pace of a search.
`include "grid_astar_path_finder_defines.svh"
module grid_astar_path_finder #(
	parameter int GRID_W     = gapf_pkg::GRID_W_DEF,
	parameter int GRID_H     = gapf_pkg::GRID_H_DEF,
	parameter int OPEN_DEPTH = gapf_pkg::OPEN_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[1:0], start_x[8:2], start_y[15:9], target_x[22:16], target_y[29:23],
	// blocked[30], step_index[44:31], zero pad[47:45]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], path_length[17:3], cell_x[24:18], cell_y[31:25]
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	localparam int CELLS   = GRID_W * GRID_H;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int KW      = CELL_AW + 1;
	localparam int CW      = gapf_pkg::COORD_W;
	localparam int AM_W    = CELL_AW + CW + 1;

	function automatic logic [CELL_AW-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y);
		logic [AM_W-1:0] a;
		a = AM_W'(y) * AM_W'(GRID_W) + AM_W'(x);
		return a[CELL_AW-1:0];
	endfunction

	function automatic logic [CW+1:0] manh(logic [CW-1:0] x1, logic [CW-1:0] y1,
			logic [CW-1:0] x2, logic [CW-1:0] y2);
		logic [CW-1:0] dx, dy;
		dx = (x1 > x2) ? (x1 - x2) : (x2 - x1);
		dy = (y1 > y2) ? (y1 - y2) : (y2 - y1);
		return (CW+2)'(dx) + (CW+2)'(dy);
	endfunction

	gapf_pkg::ctrl_state_t state_q, nxt_state;

	logic [7:0]           map_width_q, map_height_q;
	logic [CW:0]          map_w, map_h;
	logic [CW-1:0]        sx_q, sy_q, tx_q, ty_q, cur_x_q, cur_y_q;
	logic [gapf_pkg::COST_W-1:0] cur_g_q, ng;
	logic [2:0]           dir_q;
	logic [KW-1:0]        cnt_q, k_q, stored_len_q;
	gapf_pkg::status_t    status_q;
	logic [6:0]           cx_q, cy_q;
	logic                 out_valid_q;
	logic [31:0]          out_data_q;
	logic [31:0]          len32;

	gapf_pkg::mode_t      in_mode;
	logic [CW-1:0]        in_sx, in_sy, in_tx, in_ty;
	logic                 in_blocked;
	logic [13:0]          in_idx;
	logic                 in_acc, in_off_map, in_range, in_grid, out_load;
	logic [KW-1:0]        rd_path_idx;

	logic [CW:0]          nb_x9, nb_y9, tb_x9, tb_y9;
	logic                 nb_edge, nb_in, tb_out, tb_last;

	logic [CELL_AW-1:0]   wr_addr, rd_addr;
	gapf_pkg::store_wr_t  wr;
	logic                 tile_q, closed_q;
	gapf_pkg::node_t      node_q;
	logic [2*CW-1:0]      path_q;

	gapf_pkg::heap_req_t   hreq;
	gapf_pkg::heap_stat_t  hstat;
	gapf_pkg::open_entry_t hpush, htop;
	logic                  at_target;

	gapf_cell_store #(.CELLS(CELLS)) u_store (
		.clk      (clk),
		.wr_addr  (wr_addr),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.tile_q   (tile_q),
		.closed_q (closed_q),
		.node_q   (node_q),
		.path_q   (path_q)
	);

	gapf_open_heap #(.OPEN_DEPTH(OPEN_DEPTH)) u_heap (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (hreq),
		.push_entry (hpush),
		.stat       (hstat),
		.top        (htop)
	);

	assign in_mode    = gapf_pkg::mode_t'(s_tdata[1:0]);
	assign in_sx      = CW'(s_tdata[8:2]);
	assign in_sy      = CW'(s_tdata[15:9]);
	assign in_tx      = CW'(s_tdata[22:16]);
	assign in_ty      = CW'(s_tdata[29:23]);
	assign in_blocked = s_tdata[30];
	assign in_idx     = s_tdata[44:31];

	assign s_tready = (state_q == gapf_pkg::S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == gapf_pkg::S_DONE) && (!out_valid_q || m_tready);

	assign map_w = ({1'b0, map_width_q} > 9'(GRID_W)) ? (CW+1)'(GRID_W) :
		(CW+1)'(map_width_q);
	assign map_h = ({1'b0, map_height_q} > 9'(GRID_H)) ? (CW+1)'(GRID_H) :
		(CW+1)'(map_height_q);

	assign in_off_map = ({1'b0, in_sx} >= map_w) || ({1'b0, in_sy} >= map_h) ||
		({1'b0, in_tx} >= map_w) || ({1'b0, in_ty} >= map_h);
	assign in_grid    = ({1'b0, in_sx} < (CW+1)'(GRID_W)) &&
		({1'b0, in_sy} < (CW+1)'(GRID_H));
	assign in_range    = (32'(in_idx) < 32'(stored_len_q));
	assign rd_path_idx = stored_len_q - KW'(1) - KW'(in_idx);

	assign ng        = cur_g_q + gapf_pkg::COST_W'(1);
	assign at_target = (htop.x == tx_q) && (htop.y == ty_q);
	assign tb_last   = ((cur_x_q == sx_q) && (cur_y_q == sy_q)) ||
		(k_q == KW'(CELLS - 1));

	always_comb begin
		nb_x9   = {1'b0, cur_x_q};
		nb_y9   = {1'b0, cur_y_q};
		nb_edge = 1'b0;
		case (gapf_pkg::dir_t'(dir_q[1:0]))
			gapf_pkg::DIR_LEFT: begin
				nb_edge = (cur_x_q == '0);
				nb_x9   = {1'b0, cur_x_q} - (CW+1)'(1);
			end
			gapf_pkg::DIR_RIGHT: begin
				nb_x9 = {1'b0, cur_x_q} + (CW+1)'(1);
			end
			gapf_pkg::DIR_UP: begin
				nb_edge = (cur_y_q == '0);
				nb_y9   = {1'b0, cur_y_q} - (CW+1)'(1);
			end
			gapf_pkg::DIR_DOWN: begin
				nb_y9 = {1'b0, cur_y_q} + (CW+1)'(1);
			end
			default: begin
				nb_edge = 1'b1;
			end
		endcase
		nb_in = !nb_edge && (nb_x9 < map_w) && (nb_y9 < map_h);
	end

	// parent lies opposite to the move that reached this cell
	always_comb begin
		tb_x9  = {1'b0, cur_x_q};
		tb_y9  = {1'b0, cur_y_q};
		tb_out = 1'b0;
		case (node_q.dir)
			gapf_pkg::DIR_LEFT: begin
				tb_x9 = {1'b0, cur_x_q} + (CW+1)'(1);
			end
			gapf_pkg::DIR_RIGHT: begin
				tb_out = (cur_x_q == '0);
				tb_x9  = {1'b0, cur_x_q} - (CW+1)'(1);
			end
			gapf_pkg::DIR_UP: begin
				tb_y9 = {1'b0, cur_y_q} + (CW+1)'(1);
			end
			gapf_pkg::DIR_DOWN: begin
				tb_out = (cur_y_q == '0);
				tb_y9  = {1'b0, cur_y_q} - (CW+1)'(1);
			end
			default: begin
				tb_out = 1'b1;
			end
		endcase
		if ((tb_x9 >= (CW+1)'(GRID_W)) || (tb_y9 >= (CW+1)'(GRID_H))) begin
			tb_out = 1'b1;
		end
	end

	always_comb begin
		nxt_state = state_q;
		wr        = '0;
		wr_addr   = cell_addr(nb_x9[CW-1:0], nb_y9[CW-1:0]);
		rd_addr   = cell_addr(nb_x9[CW-1:0], nb_y9[CW-1:0]);
		hreq      = '0;
		hpush     = '0;
		hpush.x   = nb_x9[CW-1:0];
		hpush.y   = nb_y9[CW-1:0];
		hpush.g   = ng;
		hpush.f   = gapf_pkg::F_W'(ng) +
			gapf_pkg::F_W'(manh(nb_x9[CW-1:0], nb_y9[CW-1:0], tx_q, ty_q));
		case (state_q)
			gapf_pkg::S_CLR_TILE: begin
				wr.tile_we = 1'b1;
				wr_addr    = cnt_q[CELL_AW-1:0];
				if (cnt_q == KW'(CELLS - 1)) begin
					nxt_state = gapf_pkg::S_IDLE;
				end
			end
			gapf_pkg::S_IDLE: begin
				rd_addr = rd_path_idx[CELL_AW-1:0];
				if (in_acc) begin
					case (in_mode)
						gapf_pkg::MODE_TILE: begin
							wr.tile_we = in_grid;
							wr.tile_d  = in_blocked;
							wr_addr    = cell_addr(in_sx, in_sy);
							nxt_state  = gapf_pkg::S_DONE;
						end
						gapf_pkg::MODE_SEARCH: begin
							nxt_state = in_off_map ? gapf_pkg::S_DONE : gapf_pkg::S_CLR_NODE;
						end
						gapf_pkg::MODE_READ: begin
							nxt_state = in_range ? gapf_pkg::S_RD_PATH : gapf_pkg::S_DONE;
						end
						default: begin
							nxt_state = gapf_pkg::S_DONE;
						end
					endcase
				end
			end
			gapf_pkg::S_CLR_NODE: begin
				wr.closed_we = 1'b1;
				wr.node_we   = 1'b1;
				wr_addr      = cnt_q[CELL_AW-1:0];
				hreq.clear   = 1'b1;
				if (cnt_q == KW'(CELLS - 1)) begin
					nxt_state = gapf_pkg::S_SEED;
				end
			end
			gapf_pkg::S_SEED: begin
				wr.node_we     = 1'b1;
				wr.node_d.seen = 1'b1;
				wr_addr        = cell_addr(sx_q, sy_q);
				hreq.push      = 1'b1;
				hpush.x        = sx_q;
				hpush.y        = sy_q;
				hpush.g        = '0;
				hpush.f        = gapf_pkg::F_W'(manh(sx_q, sy_q, tx_q, ty_q));
				nxt_state      = gapf_pkg::S_POP;
			end
			gapf_pkg::S_POP: begin
				if (!hstat.busy) begin
					if (hstat.empty) begin
						nxt_state = gapf_pkg::S_DONE;
					end else begin
						hreq.pop  = 1'b1;
						nxt_state = gapf_pkg::S_POP_WAIT;
					end
				end
			end
			gapf_pkg::S_POP_WAIT: begin
				if (!hstat.busy) begin
					if (at_target) begin
						nxt_state = gapf_pkg::S_TB_RD;
					end else begin
						wr.closed_we = 1'b1;
						wr.closed_d  = 1'b1;
						wr_addr      = cell_addr(htop.x, htop.y);
						nxt_state    = gapf_pkg::S_NB;
					end
				end
			end
			gapf_pkg::S_NB: begin
				if (dir_q[2]) begin
					nxt_state = gapf_pkg::S_POP;
				end else if (nb_in) begin
					nxt_state = gapf_pkg::S_NB_CHK;
				end
			end
			gapf_pkg::S_NB_CHK: begin
				if (tile_q || closed_q || (node_q.seen && (node_q.cost <= ng))) begin
					nxt_state = gapf_pkg::S_NB;
				end else if (!hstat.busy) begin
					if (hstat.full) begin
						nxt_state = gapf_pkg::S_DONE;
					end else begin
						hreq.push      = 1'b1;
						wr.node_we     = 1'b1;
						wr.node_d.seen = 1'b1;
						wr.node_d.cost = ng;
						wr.node_d.dir  = gapf_pkg::dir_t'(dir_q[1:0]);
						nxt_state      = gapf_pkg::S_NB;
					end
				end
			end
			gapf_pkg::S_TB_RD: begin
				wr.path_we = 1'b1;
				wr.path_d  = {cur_y_q, cur_x_q};
				wr_addr    = k_q[CELL_AW-1:0];
				rd_addr    = cell_addr(cur_x_q, cur_y_q);
				nxt_state  = tb_last ? gapf_pkg::S_DONE : gapf_pkg::S_TB_STEP;
			end
			gapf_pkg::S_TB_STEP: begin
				nxt_state = tb_out ? gapf_pkg::S_DONE : gapf_pkg::S_TB_RD;
			end
			gapf_pkg::S_RD_PATH: begin
				nxt_state = gapf_pkg::S_DONE;
			end
			gapf_pkg::S_DONE: begin
				if (out_load) begin
					nxt_state = gapf_pkg::S_IDLE;
				end
			end
			default: begin
				nxt_state = gapf_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gapf_pkg::S_CLR_TILE;
			map_width_q  <= gapf_pkg::MAP_W_RESET;
			map_height_q <= gapf_pkg::MAP_H_RESET;
			cnt_q        <= '0;
			dir_q        <= '0;
			k_q          <= '0;
			stored_len_q <= '0;
			status_q     <= gapf_pkg::ST_DONE;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (cfg_we) begin
				case (cfg_index)
					gapf_pkg::REG_WIDTH:  map_width_q  <= cfg_wdata;
					gapf_pkg::REG_HEIGHT: map_height_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				gapf_pkg::S_CLR_TILE, gapf_pkg::S_CLR_NODE: begin
					cnt_q <= (cnt_q == KW'(CELLS - 1)) ? '0 : cnt_q + KW'(1);
				end
				gapf_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						status_q <= gapf_pkg::ST_DONE;
						if (in_mode == gapf_pkg::MODE_SEARCH) begin
							stored_len_q <= '0;
							if (in_off_map) begin
								status_q <= gapf_pkg::ST_NO_PATH;
							end
						end
						if ((in_mode == gapf_pkg::MODE_READ) && !in_range) begin
							status_q <= gapf_pkg::ST_RANGE;
						end
					end
				end
				gapf_pkg::S_POP: begin
					if (!hstat.busy && hstat.empty) begin
						status_q <= gapf_pkg::ST_NO_PATH;
					end
				end
				gapf_pkg::S_POP_WAIT: begin
					dir_q <= '0;
					k_q   <= '0;
				end
				gapf_pkg::S_NB: begin
					if (!dir_q[2] && !nb_in) begin
						dir_q <= dir_q + 3'd1;
					end
				end
				gapf_pkg::S_NB_CHK: begin
					if (tile_q || closed_q || (node_q.seen && (node_q.cost <= ng))) begin
						dir_q <= dir_q + 3'd1;
					end else if (!hstat.busy) begin
						if (hstat.full) begin
							status_q     <= gapf_pkg::ST_OVERFLOW;
							stored_len_q <= '0;
						end else begin
							dir_q <= dir_q + 3'd1;
						end
					end
				end
				gapf_pkg::S_TB_RD: begin
					k_q <= k_q + KW'(1);
					if (tb_last) begin
						stored_len_q <= k_q + KW'(1);
						status_q     <= gapf_pkg::ST_FOUND;
					end
				end
				gapf_pkg::S_TB_STEP: begin
					if (tb_out) begin
						stored_len_q <= k_q;
						status_q     <= gapf_pkg::ST_FOUND;
					end
				end
				default: ;
			endcase
		end
	end

	assign len32 = 32'(stored_len_q);

	always_ff @(posedge clk) begin
		case (state_q)
			gapf_pkg::S_IDLE: begin
				if (in_acc) begin
					sx_q <= in_sx;
					sy_q <= in_sy;
					tx_q <= in_tx;
					ty_q <= in_ty;
					cx_q <= '0;
					cy_q <= '0;
				end
			end
			gapf_pkg::S_POP_WAIT: begin
				cur_x_q <= htop.x;
				cur_y_q <= htop.y;
				cur_g_q <= htop.g;
			end
			gapf_pkg::S_TB_STEP: begin
				cur_x_q <= tb_x9[CW-1:0];
				cur_y_q <= tb_y9[CW-1:0];
			end
			gapf_pkg::S_RD_PATH: begin
				cx_q <= path_q[6:0];
				cy_q <= path_q[CW+6:CW];
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {cy_q, cx_q, len32[14:0], status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`GAPF_CHECK(a_heap_quiet_idle, (state_q == gapf_pkg::S_IDLE) |-> !hstat.busy, "heap active while idle")
	`GAPF_CHECK_NEXT(a_one_at_a_time, in_acc, !s_tready, "second word taken during work")
	`GAPF_CHECK(a_path_in_store, (state_q == gapf_pkg::S_TB_RD) |-> (k_q < KW'(CELLS)), "path index past store")

endmodule

// ===== dv/tb_grid_astar_path_finder.sv =====
// Self-checking testbench for the grid A* path finder: directed and random words.
`timescale 1ns / 100ps
module tb_grid_astar_path_finder;

	localparam int GW = 128;
	localparam int GH = 128;
	localparam int CELL_N = GW * GH;
	localparam int OL_DEPTH = 4096;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct packed {
		logic [2:0]      pad;
		logic [13:0]     step_index;
		logic            blocked;
		logic [6:0]      target_y;
		logic [6:0]      target_x;
		logic [6:0]      start_y;
		logic [6:0]      start_x;
		gapf_pkg::mode_t mode;
	} cmd_word_t;

	typedef struct packed {
		logic [6:0]        cell_y;
		logic [6:0]        cell_x;
		logic [14:0]       path_length;
		gapf_pkg::status_t status;
	} rsp_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;

	grid_astar_path_finder u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// model of the block
	int unsigned mdl_w, mdl_h;
	bit          mdl_tile[CELL_N];
	int unsigned mdl_cost[CELL_N];
	bit          mdl_seen[CELL_N];
	bit          mdl_closed[CELL_N];
	bit [1:0]    mdl_dir[CELL_N];
	int unsigned ol_f[OL_DEPTH], ol_seq[OL_DEPTH], ol_cell[OL_DEPTH], ol_g[OL_DEPTH];
	int unsigned ol_n, ol_seq_next;
	int unsigned route_x[CELL_N], route_y[CELL_N];
	int unsigned route_len;

	rsp_word_t   pending_rsp[$];
	int          err_cnt;
	longint      cycle_cnt;
	int          n_tile, n_found, n_nopath, n_read, n_range, n_cfg;
	bit          calm;

	function automatic bit ol_before(int unsigned a, int unsigned b);
		return ol_f[a] < ol_f[b] || (ol_f[a] == ol_f[b] && ol_seq[a] < ol_seq[b]);
	endfunction

	function automatic void ol_swap(int unsigned a, int unsigned b);
		int unsigned t;
		t = ol_f[a]; ol_f[a] = ol_f[b]; ol_f[b] = t;
		t = ol_seq[a]; ol_seq[a] = ol_seq[b]; ol_seq[b] = t;
		t = ol_cell[a]; ol_cell[a] = ol_cell[b]; ol_cell[b] = t;
		t = ol_g[a]; ol_g[a] = ol_g[b]; ol_g[b] = t;
	endfunction

	function automatic bit ol_push(int unsigned c, int unsigned g, int unsigned f);
		int unsigned i;
		if (ol_n >= OL_DEPTH)
			return 1'b0;
		i = ol_n;
		ol_n++;
		ol_f[i] = f; ol_g[i] = g; ol_cell[i] = c; ol_seq[i] = ol_seq_next;
		ol_seq_next++;
		while (i > 0 && ol_before(i, (i - 1) / 2)) begin
			ol_swap(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
		return 1'b1;
	endfunction

	function automatic void ol_pop(output int unsigned c, output int unsigned g);
		int unsigned i, l, r, m;
		c = ol_cell[0];
		g = ol_g[0];
		ol_n--;
		ol_f[0] = ol_f[ol_n]; ol_seq[0] = ol_seq[ol_n];
		ol_cell[0] = ol_cell[ol_n]; ol_g[0] = ol_g[ol_n];
		i = 0;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			m = i;
			if (l < ol_n && ol_before(l, m)) m = l;
			if (r < ol_n && ol_before(r, m)) m = r;
			if (m == i)
				break;
			ol_swap(i, m);
			i = m;
		end
	endfunction

	function automatic int unsigned manhattan(int x1, int y1, int x2, int y2);
		return (x1 > x2 ? x1 - x2 : x2 - x1) + (y1 > y2 ? y1 - y2 : y2 - y1);
	endfunction

	function automatic void trace_route(int unsigned start, int unsigned target);
		int unsigned cur, k, i, t;
		int px, py;
		cur = target;
		k = 0;
		while (k < CELL_N) begin
			route_x[k] = cur % GW;
			route_y[k] = cur / GW;
			k++;
			if (cur == start)
				break;
			px = int'(cur % GW);
			py = int'(cur / GW);
			case (gapf_pkg::dir_t'(mdl_dir[cur]))
				gapf_pkg::DIR_LEFT:  px = px + 1;
				gapf_pkg::DIR_RIGHT: px = px - 1;
				gapf_pkg::DIR_UP:    py = py + 1;
				default:             py = py - 1;
			endcase
			if (px < 0 || py < 0 || px >= GW || py >= GH)
				break;
			cur = py * GW + px;
		end
		for (i = 0; i < k / 2; i++) begin
			t = route_x[i]; route_x[i] = route_x[k - 1 - i]; route_x[k - 1 - i] = t;
			t = route_y[i]; route_y[i] = route_y[k - 1 - i]; route_y[k - 1 - i] = t;
		end
		route_len = k;
	endfunction

	function automatic gapf_pkg::status_t plan_route(int sx, int sy, int tx, int ty);
		int w, h, cx, cy, nx, ny, d;
		int unsigned start, target, c, g, n;
		w = mdl_w > GW ? GW : mdl_w;
		h = mdl_h > GH ? GH : mdl_h;
		route_len = 0;
		if (sx >= w || sy >= h || tx >= w || ty >= h)
			return gapf_pkg::ST_NO_PATH;
		for (int k = 0; k < CELL_N; k++) begin
			mdl_seen[k] = 1'b0;
			mdl_closed[k] = 1'b0;
		end
		ol_n = 0;
		ol_seq_next = 0;
		start = sy * GW + sx;
		target = ty * GW + tx;
		mdl_seen[start] = 1'b1;
		mdl_cost[start] = 0;
		void'(ol_push(start, 0, manhattan(sx, sy, tx, ty)));
		while (ol_n > 0) begin
			ol_pop(c, g);
			if (c == target) begin
				trace_route(start, target);
				return gapf_pkg::ST_FOUND;
			end
			mdl_closed[c] = 1'b1;
			cx = int'(c % GW);
			cy = int'(c / GW);
			for (d = 0; d < 4; d++) begin
				nx = cx + (d == 0 ? -1 : d == 1 ? 1 : 0);
				ny = cy + (d == 2 ? -1 : d == 3 ? 1 : 0);
				if (nx < 0 || ny < 0 || nx >= w || ny >= h)
					continue;
				n = ny * GW + nx;
				if (mdl_tile[n] || mdl_closed[n])
					continue;
				if (mdl_seen[n] && mdl_cost[n] <= g + 1)
					continue;
				if (!ol_push(n, g + 1, g + 1 + manhattan(nx, ny, tx, ty))) begin
					route_len = 0;
					return gapf_pkg::ST_OVERFLOW;
				end
				mdl_seen[n] = 1'b1;
				mdl_cost[n] = g + 1;
				mdl_dir[n] = d[1:0];
			end
		end
		return gapf_pkg::ST_NO_PATH;
	endfunction

	function automatic rsp_word_t model_word(cmd_word_t c);
		rsp_word_t r;
		r = '0;
		r.status = gapf_pkg::ST_DONE;
		case (c.mode)
			gapf_pkg::MODE_TILE: begin
				mdl_tile[c.start_y * GW + c.start_x] = c.blocked;
				n_tile++;
			end
			gapf_pkg::MODE_SEARCH: begin
				r.status = plan_route(int'(c.start_x), int'(c.start_y),
					int'(c.target_x), int'(c.target_y));
				if (r.status == gapf_pkg::ST_FOUND) n_found++;
				else n_nopath++;
			end
			gapf_pkg::MODE_READ: begin
				n_read++;
				if (c.step_index < route_len) begin
					r.cell_x = 7'(route_x[c.step_index]);
					r.cell_y = 7'(route_y[c.step_index]);
				end else begin
					r.status = gapf_pkg::ST_RANGE;
					n_range++;
				end
			end
			default: ;
		endcase
		r.path_length = 15'(route_len);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(cmd_word_t c);
		int gap;
		s_tdata <= c;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_rsp = {pending_rsp, model_word(c)};
		gap = pick_gap();
		s_tvalid <= 1'b0;
		@(posedge clk);
		repeat (gap) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] val);
		wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gapf_pkg::REG_WIDTH) mdl_w = 32'(val);
		else mdl_h = 32'(val);
		n_cfg++;
	endtask

	function automatic cmd_word_t mk(gapf_pkg::mode_t m, int sx, int sy, int tx, int ty,
		bit blk, int idx);
		cmd_word_t c;
		c = '0;
		c.mode = m;
		c.start_x = 7'(sx); c.start_y = 7'(sy);
		c.target_x = 7'(tx); c.target_y = 7'(ty);
		c.blocked = blk;
		c.step_index = 14'(idx);
		return c;
	endfunction

	task automatic test_defaults();
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_SEARCH, 3, 4, 3, 4, 0, 0));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 1));
		send_word(mk(gapf_pkg::MODE_NONE, 127, 127, 127, 127, 1, 16383));
		send_word(mk(gapf_pkg::MODE_SEARCH, 100, 0, 1, 1, 0, 0));
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 0, 127, 0, 0));
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 5, 3, 0, 0));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 4));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 8));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 16383));
	endtask

	task automatic test_blocked_tiles();
		send_word(mk(gapf_pkg::MODE_TILE, 0, 0, 9, 9, 1, 77));
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 2, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_TILE, 0, 0, 0, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_TILE, 127, 127, 0, 0, 1, 0));
		send_word(mk(gapf_pkg::MODE_TILE, 127, 127, 0, 0, 0, 0));
		// wall across a 3x3 map leaves no route
		write_reg(gapf_pkg::REG_WIDTH, 8'd3);
		write_reg(gapf_pkg::REG_HEIGHT, 8'd3);
		for (int y = 0; y < 3; y++)
			send_word(mk(gapf_pkg::MODE_TILE, 1, y, 0, 0, 1, 0));
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 2, 2, 0, 0));
		send_word(mk(gapf_pkg::MODE_TILE, 1, 2, 0, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 2, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 6));
		for (int y = 0; y < 2; y++)
			send_word(mk(gapf_pkg::MODE_TILE, 1, y, 0, 0, 0, 0));
	endtask

	task automatic test_map_limits();
		write_reg(gapf_pkg::REG_WIDTH, 8'd1);
		write_reg(gapf_pkg::REG_HEIGHT, 8'd1);
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 0, 0, 0, 0));
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 1, 0, 0, 0));
		write_reg(gapf_pkg::REG_WIDTH, 8'd0);
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 0, 0, 0, 0));
		write_reg(gapf_pkg::REG_WIDTH, 8'd255);
		write_reg(gapf_pkg::REG_HEIGHT, 8'd128);
		send_word(mk(gapf_pkg::MODE_SEARCH, 120, 121, 127, 127, 0, 0));
		send_word(mk(gapf_pkg::MODE_READ, 0, 0, 0, 0, 0, 13));
		write_reg(gapf_pkg::REG_HEIGHT, 8'd0);
		send_word(mk(gapf_pkg::MODE_SEARCH, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random(int n_items);
		int w, h, r, sx, sy;
		cmd_word_t c;
		for (int i = 0; i < n_items; i++) begin
			if (i % 20 == 0) begin
				wait_drained();
				calm = ($urandom_range(0, 3) == 0);
				if (i == 40) begin
					w = 128;
					h = 128;
				end else begin
					w = $urandom_range(2, 16);
					h = $urandom_range(2, 16);
				end
				write_reg(gapf_pkg::REG_WIDTH, 8'(w));
				write_reg(gapf_pkg::REG_HEIGHT, 8'(h));
			end
			c = cmd_word_t'(48'($urandom()));
			c[47:32] = 16'($urandom());
			c.pad = '0;
			r = $urandom_range(0, 99);
			if (r < 35) begin
				c.mode = gapf_pkg::MODE_TILE;
				c.start_x = 7'($urandom_range(0, w - 1));
				c.start_y = 7'($urandom_range(0, h - 1));
				c.blocked = ($urandom_range(0, 99) < 30);
			end else if (r < 65) begin
				c.mode = gapf_pkg::MODE_SEARCH;
				if ($urandom_range(0, 99) < 88) begin
					sx = $urandom_range(0, w - 1);
					sy = $urandom_range(0, h - 1);
					c.start_x = 7'(sx);
					c.start_y = 7'(sy);
					if (w > 16) begin
						// keep searches on the full map short
						c.target_x = 7'($urandom_range(sx, sx + 8 < w ? sx + 8 : w - 1));
						c.target_y = 7'($urandom_range(sy, sy + 8 < h ? sy + 8 : h - 1));
					end else begin
						c.target_x = 7'($urandom_range(0, w - 1));
						c.target_y = 7'($urandom_range(0, h - 1));
					end
				end
			end else if (r < 95) begin
				c.mode = gapf_pkg::MODE_READ;
				if (route_len > 0 && $urandom_range(0, 99) < 80)
					c.step_index = 14'($urandom_range(0, route_len - 1));
			end else begin
				c.mode = gapf_pkg::MODE_NONE;
			end
			send_word(c);
			if (i == 50) begin
				// hold off until the block has drained
				wait_drained();
				s_tvalid <= 1'b0;
				repeat (5) @(posedge clk);
			end
		end
		calm = 1'b0;
	endtask

	// response side: random backpressure and checking
	int stall_left;
	always @(posedge clk) begin
		rsp_word_t got, want;
		int r;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				err_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					err_cnt++;
				end
				if (got.path_length !== want.path_length) begin
					$display("%0t: path_length exp %0d got %0d", $time,
						want.path_length, got.path_length);
					err_cnt++;
				end
				if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y) begin
					$display("%0t: cell exp (%0d,%0d) got (%0d,%0d)", $time,
						want.cell_x, want.cell_y, got.cell_x, got.cell_y);
					err_cnt++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 100);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		mdl_w = 32'(gapf_pkg::MAP_W_RESET);
		mdl_h = 32'(gapf_pkg::MAP_H_RESET);
		route_len = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_blocked_tiles();
		test_map_limits();
		test_random(70);
		wait_drained();
		s_tvalid <= 1'b0;
		repeat (50) @(posedge clk);
		$display("Covered %0d tile writes, %0d routes found, %0d searches without route,",
			n_tile, n_found, n_nopath);
		$display("%0d path reads (%0d out of range) and %0d register writes.",
			n_read, n_range, n_cfg);
		if (err_cnt == 0 && pending_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== grid_astar_path_finder.f =====
+incdir+sv
sv/gapf_pkg.sv
sv/gapf_cell_store.sv
sv/gapf_open_heap.sv
sv/grid_astar_path_finder.sv
dv/tb_grid_astar_path_finder.sv
